>>> hw/rtl/trsp_pkg.sv
package trsp_pkg;

  localparam int unsigned BODY_LEN_W = 16;
  localparam int unsigned MAX_LEN_RESET = 2048;
  localparam int unsigned NAME_LEN = 15;
  localparam int unsigned METHOD_LEN = 3;

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    HF_NAME  = 2'd0,
    HF_BLANK = 2'd1,
    HF_DIGIT = 2'd2,
    HF_SKIP  = 2'd3
  } hdr_field_t;

  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_NO_BODY = 2'd1,
    KIND_BAD_REQ = 2'd2,
    KIND_BAD_EOL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    METH_HBT = 2'd0,
    METH_LGN = 2'd1,
    METH_RGT = 2'd2,
    METH_LGT = 2'd3
  } method_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            body_byte;
    method_t               method;
    logic [BODY_LEN_W-1:0] body_length;
    logic                  last;
  } result_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  // Character of a method name at position 0..2.
  function automatic logic [7:0] method_char(input logic [1:0] m, input logic [1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (m)
      METH_HBT: c = (pos == 2'd0) ? "H" : (pos == 2'd1) ? "B" : "T";
      METH_LGN: c = (pos == 2'd0) ? "L" : (pos == 2'd1) ? "G" : "N";
      METH_RGT: c = (pos == 2'd0) ? "R" : (pos == 2'd1) ? "G" : "T";
      METH_LGT: c = (pos == 2'd0) ? "L" : (pos == 2'd1) ? "G" : "T";
      default:  c = 8'h00;
    endcase
    method_char = c;
  endfunction

  // Upper-case text of the length header name, "CONTENT-LENGTH:".
  function automatic logic [7:0] length_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "C";
      4'd1:    c = "O";
      4'd2:    c = "N";
      4'd3:    c = "T";
      4'd4:    c = "E";
      4'd5:    c = "N";
      4'd6:    c = "T";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "E";
      4'd10:   c = "N";
      4'd11:   c = "G";
      4'd12:   c = "T";
      4'd13:   c = "H";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    length_char = c;
  endfunction

endpackage

>>> hw/rtl/text_request_stream_parser_top.sv
// Byte-serial request parser.
// Input channel (in_valid / in_stall / in_rx_byte) carries one received byte
// per beat. The first CRLF line must be one of HBT, LGN, RGT, LGT (any case),
// header lines follow, a Content-Length header sets the body size, a blank
// line ends the headers and the body bytes then stream out one per beat.
// Result channel (out_valid / out_stall / out_* fields) carries at most one
// result per input beat: a body byte, a body-less packet marker, or an error
// (bad request, malformed line ending) that restarts the parser.
// Configuration: APB write of max_body_length at byte address 0.
// Each result is registered (result or skid register) before it reaches out_valid.
// Throughput: one byte per cycle unless in_stall is high; each byte updates
// a few small registers via one pass of logic from input to result register.
// Stalls: a two-entry output buffer (result register plus skid register)
// absorbs one stalled result; in_stall rises only while the skid holds one.
// Reset (rst_n low, synchronous): parser returns to the request line,
// buffers empty, max_body_length back to 2048.
module text_request_stream_parser_top
  import trsp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_body_byte,
  output logic [1:0]            out_method,
  output logic [BODY_LEN_W-1:0] out_body_length,
  output logic                  out_last,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Declared length holds up to 2^LENGTH_BITS, so one extra bit.
  localparam int unsigned DW = LENGTH_BITS + 1;
  localparam int unsigned MW = DW + 4;
  localparam logic [MW-1:0] LEN_CAP = MW'(1) << LENGTH_BITS;

  // ---------------------------------------------------------------- config
  logic [BODY_LEN_W-1:0] max_len_r;
  logic                  cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'b0);
  assign prdata  = cfg_hit ? {{(32-BODY_LEN_W){1'b0}}, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= BODY_LEN_W'(MAX_LEN_RESET);
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      max_len_r <= pwdata[BODY_LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------- state
  phase_t     phase_r,   phase_nxt;
  logic       prev_cr_r, prev_cr_nxt;
  logic [3:0] cand_r,    cand_nxt;
  logic [4:0] pos_r,     pos_nxt;
  method_t    meth_r,    meth_nxt;
  hdr_field_t hf_r,      hf_nxt;
  logic [DW-1:0] decl_r, decl_nxt;
  logic [DW-1:0] rem_r,  rem_nxt;

  logic    in_acc;
  logic    res_vld;
  result_t res;
  logic    restart;

  // Per-byte helpers
  logic [7:0]             up;
  logic                   is_digit;
  logic                   is_blank;
  logic [3:0]             digit;
  logic [MW-1:0]          dec_ext;
  logic [MW-1:0]          acc10;
  logic [MW-1:0]          acc_sat;
  logic [DW+BODY_LEN_W-1:0] decl_wide;
  logic [BODY_LEN_W-1:0]  decl16;
  logic                   over_max;
  logic [3:0]             cand_hit;
  logic [1:0]             first_cand;

  assign in_acc   = in_valid && !in_stall;
  assign up       = upcase(in_rx_byte);
  assign is_digit = (in_rx_byte >= "0") && (in_rx_byte <= "9");
  assign is_blank = (in_rx_byte == CH_SP) || (in_rx_byte == CH_TAB);
  assign digit    = in_rx_byte[3:0];
  assign dec_ext  = {4'd0, decl_r};
  // x*10 + d as shift-and-add, saturated at 2^LENGTH_BITS
  assign acc10    = (dec_ext << 3) + (dec_ext << 1) + MW'(digit);
  assign acc_sat  = (acc10 > LEN_CAP) ? LEN_CAP : acc10;

  assign decl_wide = {{BODY_LEN_W{1'b0}}, decl_r};
  assign decl16    = decl_wide[BODY_LEN_W-1:0];
  assign over_max  = decl_wide > (DW+BODY_LEN_W)'(max_len_r);

  // Drop candidates whose letter at this position differs.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand_hit[k] = (up == method_char(2'(k), pos_r[1:0]));
    end
  end

  always_comb begin
    priority if (cand_r[0]) first_cand = METH_HBT;
    else if (cand_r[1])     first_cand = METH_LGN;
    else if (cand_r[2])     first_cand = METH_RGT;
    else                    first_cand = METH_LGT;
  end

  // Next state and result for one accepted byte
  always_comb begin
    phase_nxt   = phase_r;
    prev_cr_nxt = prev_cr_r;
    cand_nxt    = cand_r;
    pos_nxt     = pos_r;
    meth_nxt    = meth_r;
    hf_nxt      = hf_r;
    decl_nxt    = decl_r;
    rem_nxt     = rem_r;
    restart     = 1'b0;
    res_vld     = 1'b0;
    res         = '0;

    if (in_acc) begin
      if (phase_r == PH_BODY) begin
        // Stream the body byte; no line-ending checks here.
        res_vld         = 1'b1;
        res.kind        = KIND_BODY;
        res.body_byte   = in_rx_byte;
        res.method      = meth_r;
        res.body_length = decl16;
        if (rem_r <= DW'(1)) begin
          res.last = 1'b1;
          restart  = 1'b1;
        end else begin
          rem_nxt = rem_r - DW'(1);
        end
      end else if (prev_cr_r) begin
        prev_cr_nxt = 1'b0;
        if (in_rx_byte != CH_LF) begin
          res_vld  = 1'b1;
          res.kind = KIND_BAD_EOL;
          res.last = 1'b1;
          restart  = 1'b1;
        end else if (phase_r == PH_LINE) begin
          // End of request line
          if (pos_r == 5'd3 && cand_r != 4'd0) begin
            meth_nxt  = method_t'(first_cand);
            phase_nxt = PH_HDR;
            pos_nxt   = 5'd0;
            hf_nxt    = HF_NAME;
          end else begin
            res_vld  = 1'b1;
            res.kind = KIND_BAD_REQ;
            res.last = 1'b1;
            restart  = 1'b1;
          end
        end else if (hf_r == HF_NAME && pos_r == 5'd0) begin
          // Blank line ends the headers
          if (over_max) begin
            res_vld  = 1'b1;
            res.kind = KIND_BAD_REQ;
            res.last = 1'b1;
            restart  = 1'b1;
          end else if (decl_r == '0) begin
            res_vld    = 1'b1;
            res.kind   = KIND_NO_BODY;
            res.method = meth_r;
            res.last   = 1'b1;
            restart    = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
            rem_nxt   = decl_r;
          end
        end else begin
          pos_nxt = 5'd0;
          hf_nxt  = HF_NAME;
        end
      end else if (in_rx_byte == CH_CR) begin
        prev_cr_nxt = 1'b1;
      end else if (in_rx_byte == CH_LF) begin
        res_vld  = 1'b1;
        res.kind = KIND_BAD_EOL;
        res.last = 1'b1;
        restart  = 1'b1;
      end else if (phase_r == PH_LINE) begin
        if (pos_r < 5'd3) begin
          cand_nxt = cand_r & cand_hit;
        end else begin
          cand_nxt = 4'd0;
        end
        if (pos_r < 5'd31) begin
          pos_nxt = pos_r + 5'd1;
        end
      end else begin
        unique case (hf_r)
          HF_NAME: begin
            if (pos_r < 5'(NAME_LEN) && up == length_char(pos_r[3:0])) begin
              pos_nxt = pos_r + 5'd1;
              if (pos_r == 5'(NAME_LEN - 1)) begin
                hf_nxt   = HF_BLANK;
                decl_nxt = '0;
              end
            end else begin
              hf_nxt = HF_SKIP;
            end
          end
          HF_BLANK: begin
            if (is_digit) begin
              hf_nxt   = HF_DIGIT;
              decl_nxt = DW'(digit);
            end else if (!is_blank) begin
              hf_nxt = HF_SKIP;
            end
          end
          HF_DIGIT: begin
            if (is_digit) begin
              decl_nxt = acc_sat[DW-1:0];
            end else begin
              hf_nxt = HF_SKIP;
            end
          end
          HF_SKIP: begin
          end
          default: begin
          end
        endcase
      end

      // Return every parser register to its reset value.
      if (restart) begin
        phase_nxt   = PH_LINE;
        prev_cr_nxt = 1'b0;
        cand_nxt    = 4'hf;
        pos_nxt     = 5'd0;
        meth_nxt    = METH_HBT;
        hf_nxt      = HF_NAME;
        decl_nxt    = '0;
        rem_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LINE;
      prev_cr_r <= 1'b0;
      cand_r    <= 4'hf;
      pos_r     <= 5'd0;
      meth_r    <= METH_HBT;
      hf_r      <= HF_NAME;
      decl_r    <= '0;
      rem_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      prev_cr_r <= prev_cr_nxt;
      cand_r    <= cand_nxt;
      pos_r     <= pos_nxt;
      meth_r    <= meth_nxt;
      hf_r      <= hf_nxt;
      decl_r    <= decl_nxt;
      rem_r     <= rem_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  // Result register plus one skid entry; the skid fills only when a new
  // result arrives while the held one is stalled.
  logic    out_valid_r, skid_valid_r;
  result_t out_res_r,   skid_res_r;
  logic    out_take;
  logic    load_out;
  logic    load_skid;

  assign in_stall  = skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign load_out  = (out_take || !out_valid_r) && (skid_valid_r || res_vld);
  assign load_skid = out_valid_r && !out_take && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_take || !out_valid_r) begin
        out_valid_r  <= skid_valid_r || res_vld;
        skid_valid_r <= 1'b0;
      end else if (res_vld) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end
    if (load_skid) begin
      skid_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_res_r.kind;
  assign out_body_byte   = out_res_r.body_byte;
  assign out_method      = out_res_r.method;
  assign out_body_length = out_res_r.body_length;
  assign out_last        = out_res_r.last;

endmodule

>>> bench/request_parse_checker.sv
module request_parse_checker
  import trsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            out_kind,
  input  logic [7:0]            out_body_byte,
  input  logic [1:0]            out_method,
  input  logic [BODY_LEN_W-1:0] out_body_length,
  input  logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [31:0]           pwdata,
  output int                    fail_count,
  output int                    expected_left
);

  localparam logic [0:3][23:0] METHOD_TEXT = {"HBT", "LGN", "RGT", "LGT"};
  localparam logic [119:0]     LENGTH_TAG  = "CONTENT-LENGTH:";
  localparam int unsigned      LENGTH_CAP  = 1 << BODY_LEN_W;

  // Parser copy
  phase_t                ph;
  logic                  cr_seen;
  logic [3:0]            cand;
  logic [4:0]            line_pos;
  method_t               cur_meth;
  hdr_field_t            hf;
  logic [BODY_LEN_W:0]   decl_len;
  logic [BODY_LEN_W-1:0] body_left;
  logic [BODY_LEN_W-1:0] max_len;

  result_t pending_results[$];

  task automatic clear_parse();
    ph        = PH_LINE;
    cr_seen   = 1'b0;
    cand      = 4'hf;
    line_pos  = '0;
    cur_meth  = METH_HBT;
    hf        = HF_NAME;
    decl_len  = '0;
    body_left = '0;
  endtask

  // Advance the parser by one byte; produced tells whether r holds a result.
  task automatic parse_byte(input logic [7:0] b, output bit produced, output result_t r);
    logic [7:0]  up;
    int unsigned grown;
    bit          err;
    kind_t       err_kind;
    produced = 1'b0;
    r        = '0;
    err      = 1'b0;
    err_kind = KIND_BAD_REQ;
    up       = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    if (ph == PH_BODY) begin
      produced      = 1'b1;
      r.kind        = KIND_BODY;
      r.body_byte   = b;
      r.method      = cur_meth;
      r.body_length = decl_len[BODY_LEN_W-1:0];
      r.last        = (body_left <= 1);
      if (r.last) clear_parse();
      else body_left = body_left - 1'b1;
    end else if (cr_seen) begin
      cr_seen = 1'b0;
      if (b != CH_LF) begin
        err      = 1'b1;
        err_kind = KIND_BAD_EOL;
      end else if (ph == PH_LINE) begin
        if (line_pos == METHOD_LEN && cand != 4'h0) begin
          cur_meth = cand[0] ? METH_HBT : cand[1] ? METH_LGN : cand[2] ? METH_RGT : METH_LGT;
          ph       = PH_HDR;
          line_pos = '0;
          hf       = HF_NAME;
        end else begin
          err = 1'b1;
        end
      end else if (hf == HF_NAME && line_pos == 0) begin
        // blank line closes the headers
        if (decl_len > max_len) begin
          err = 1'b1;
        end else if (decl_len == 0) begin
          produced = 1'b1;
          r.kind   = KIND_NO_BODY;
          r.method = cur_meth;
          r.last   = 1'b1;
          clear_parse();
        end else begin
          ph        = PH_BODY;
          body_left = decl_len[BODY_LEN_W-1:0];
        end
      end else begin
        line_pos = '0;
        hf       = HF_NAME;
      end
    end else if (b == CH_CR) begin
      cr_seen = 1'b1;
    end else if (b == CH_LF) begin
      err      = 1'b1;
      err_kind = KIND_BAD_EOL;
    end else if (ph == PH_LINE) begin
      if (line_pos < METHOD_LEN) begin
        for (int k = 0; k < 4; k++) begin
          if (up != METHOD_TEXT[k][23 - 8*line_pos -: 8]) cand[k] = 1'b0;
        end
      end else begin
        cand = 4'h0;
      end
      if (line_pos < 31) line_pos = line_pos + 1'b1;
    end else begin
      case (hf)
        HF_NAME: begin
          if (line_pos < NAME_LEN && up == LENGTH_TAG[119 - 8*line_pos -: 8]) begin
            line_pos = line_pos + 1'b1;
            if (line_pos == NAME_LEN) begin
              hf       = HF_BLANK;
              decl_len = '0;
            end
          end else begin
            hf = HF_SKIP;
          end
        end
        HF_BLANK: begin
          if (b >= "0" && b <= "9") begin
            hf       = HF_DIGIT;
            decl_len = (BODY_LEN_W+1)'(b - 8'h30);
          end else if (b != CH_SP && b != CH_TAB) begin
            hf = HF_SKIP;
          end
        end
        HF_DIGIT: begin
          if (b >= "0" && b <= "9") begin
            grown    = 32'(decl_len) * 10 + 32'(b - 8'h30);
            decl_len = (grown > LENGTH_CAP) ? LENGTH_CAP[BODY_LEN_W:0]
                                            : grown[BODY_LEN_W:0];
          end else begin
            hf = HF_SKIP;
          end
        end
        default: ;
      endcase
    end
    if (err) begin
      produced = 1'b1;
      r.kind   = err_kind;
      r.last   = 1'b1;
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    bit      produced;
    if (!rst_n) begin
      clear_parse();
      max_len = BODY_LEN_W'(MAX_LEN_RESET);
      pending_results.delete();
    end else begin
      // results are registered before they leave, so compare before predicting
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d, body_byte %0d", out_kind, out_body_byte);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("body_byte", 32'(want.body_byte), 32'(out_body_byte));
          check_field("method", 32'(want.method), 32'(out_method));
          check_field("body_length", 32'(want.body_length), 32'(out_body_length));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte, produced, got);
        if (produced) pending_results.push_back(got);
      end
      if (psel && penable && pwrite && pready) max_len = pwdata[BODY_LEN_W-1:0];
    end
    expected_left = pending_results.size();
  end

endmodule

>>> bench/text_request_stream_parser_top_tb.sv
module text_request_stream_parser_top_tb
  import trsp_pkg::*;
();

  // Register map: max_body_length is the only register.
  localparam logic [2:0] REG_MAX_BODY_LEN = 3'd0;

  localparam logic [0:3][23:0] METHOD_TEXT = {"HBT", "LGN", "RGT", "LGT"};
  localparam logic [119:0]     LENGTH_TAG  = "CONTENT-LENGTH:";

  // Stimulus size: total input beats and how many register settings they span.
  localparam int ITEM_TARGET = 1550;
  localparam int NUM_PHASES  = 6;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_kind;
  logic [7:0]            out_body_byte;
  logic [1:0]            out_method;
  logic [BODY_LEN_W-1:0] out_body_length;
  logic                  out_last;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int expected_left;

  // Sender state: beats accepted so far, whether idling is allowed at all,
  // and the odds (1 in gap_odds, 0 = never) of a gap before a beat.
  int bytes_sent = 0;
  bit idle_on    = 1'b1;
  int gap_odds   = 6;

  text_request_stream_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_body_byte   (out_body_byte),
    .out_method      (out_method),
    .out_body_length (out_body_length),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  request_parse_checker parse_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_body_byte   (out_body_byte),
    .out_method      (out_method),
    .out_body_length (out_body_length),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .expected_left   (expected_left)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("text_request_stream_parser_top_tb: errors");
    $finish;
  end

  // Result side: stall in random bursts while idling is on.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Flip a letter to lower case half the time; the parser ignores case.
  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) return c | 8'h20;
    return c;
  endfunction

  // Drive one beat. Call at a falling edge; return at the falling edge after
  // the beat was taken, with valid still high so back-to-back beats need no
  // second assignment. An optional gap first drops valid for a random stretch.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Line ending: CR then LF.
  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Drop valid, wait for every expected result, then wait out any beat
  // without a result that may still be in flight.
  task automatic drain();
    in_valid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned limit_now;
    int          planned_len;
    int          pick;
    int          value;
    string       digits;
    logic [7:0]  c;

    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = REG_MAX_BODY_LEN;
    pwdata     = 32'h0;
    rst_n      = 1'b0;
    limit_now  = MAX_LEN_RESET;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: lone LF, CR followed by a non-LF byte, empty request line,
    // NUL and 0xFF inside a three-byte line, an overlong method, and a
    // lower/mixed case method with no headers (packet without body).
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte("A");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hff);
    send_text("T");
    send_crlf();
    send_text("hbtx");
    send_crlf();
    send_text("lGt");
    send_crlf();
    send_crlf();

    // Random part, split across register settings: reset value first, then
    // both extremes, one, a small random limit, and the reset value again.
    for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      if (phase_idx > 0) begin
        drain();
        case (phase_idx)
          1:       limit_now = 65535;
          2:       limit_now = 0;
          3:       limit_now = 1;
          4:       limit_now = $urandom_range(2, 40);
          default: limit_now = MAX_LEN_RESET;
        endcase
        // no idling on either side in the final stretch
        idle_on = (phase_idx != NUM_PHASES - 1);
        // APB write: setup cycle, then access until pready
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = REG_MAX_BODY_LEN;
        pwdata  = limit_now;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
      end

      while (bytes_sent < ITEM_TARGET * (phase_idx + 1) / NUM_PHASES) begin
        // some sequences run gap-free, the rest gap now and then
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 6;
        if ($urandom_range(0, 3) != 0) begin
          // Well-formed request: method line, up to three headers, blank
          // line, then the body that the last length header announced.
          pick = $urandom_range(0, 3);
          for (int i = 0; i < METHOD_LEN; i++)
            send_byte(mixed_case(METHOD_TEXT[pick][23 - 8*i -: 8]));
          send_crlf();
          planned_len = 0;
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
              for (int i = 0; i < NAME_LEN; i++)
                send_byte(mixed_case(LENGTH_TAG[119 - 8*i -: 8]));
              repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
              // 0: no digits, 1: signed value, 2: over the limit (saturating
              // when the limit is at its top), 3: exactly the limit if at most 40, else small
              pick = $urandom_range(0, 9);
              if (pick == 2)
                value = (limit_now >= 65535) ? 99999 + $urandom_range(0, 9999999)
                                             : limit_now + 1 + $urandom_range(0, 300);
              else if (pick == 3 && limit_now <= 40)
                value = limit_now;
              else
                value = $urandom_range(0, 12);
              digits = $sformatf("%0d", value);
              if ($urandom_range(0, 4) == 0) digits = {"00", digits};
              if (pick == 1) send_byte($urandom_range(0, 1) ? "+" : "-");
              if (pick != 0) send_text(digits);
              planned_len = (pick <= 1) ? 0 : value;
              // trailing text after the digits is ignored
              if ($urandom_range(0, 4) == 0) send_text(" x9");
            end else begin
              // other header, sometimes opening like the length header
              repeat ($urandom_range(0, NAME_LEN - 1)) send_byte(mixed_case("C"));
              repeat ($urandom_range(1, 8)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                send_byte(c);
              end
            end
            send_crlf();
          end
          send_crlf();
          if (planned_len > 0 && planned_len <= limit_now)
            repeat (planned_len) send_byte(8'($urandom_range(0, 255)));
        end else begin
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            // raw noise, heavy on line-ending bytes
            repeat ($urandom_range(1, 12)) begin
              case ($urandom_range(0, 3))
                0:       c = CH_CR;
                1:       c = CH_LF;
                default: c = 8'($urandom_range(0, 255));
              endcase
              send_byte(c);
            end
          end else if (pick == 1) begin
            // request line of random letters, usually not a method
            repeat ($urandom_range(0, 5)) send_byte(mixed_case(8'($urandom_range("A", "Z"))));
            send_crlf();
          end else begin
            // good method line, then a header broken by a bare CR or LF
            pick = $urandom_range(0, 3);
            for (int i = 0; i < METHOD_LEN; i++)
              send_byte(mixed_case(METHOD_TEXT[pick][23 - 8*i -: 8]));
            send_crlf();
            send_text("X-");
            if ($urandom_range(0, 1) == 1) begin
              send_byte(CH_LF);
            end else begin
              send_byte(CH_CR);
              send_byte("Z");
            end
          end
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("text_request_stream_parser_top_tb: clean");
    end else begin
      $display("text_request_stream_parser_top_tb: errors");
    end
    $finish;
  end

endmodule
